// ===== src/ins_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Insertion sorter package
// Shared types for the sorting cell chain and its control.
// ----------------------------------------------------------------------------
package ins_pkg;

  // Per-cycle commands broadcast from the controller to every cell.
  typedef struct packed {
    logic insert;  // place the incoming value into the sorted chain
    logic drain;   // shift the chain down by one place toward cell 0
  } cell_ctrl_t;

endpackage

// ===== src/ins_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Insertion sorter cell
// One place of the sorted chain: holds a value, compares it with the
// incoming value and takes its new contents from itself or a neighbor.
// ----------------------------------------------------------------------------
module ins_cell import ins_pkg::*; #(
  parameter int VALUE_BITS = 16
) (
  input  logic                         clk,
  input  cell_ctrl_t                   ctrl,
  input  logic signed [VALUE_BITS-1:0] new_value,
  input  logic                         occupied,
  input  logic                         prev_occupied,
  input  logic                         prev_gt,
  input  logic signed [VALUE_BITS-1:0] prev_value,
  input  logic signed [VALUE_BITS-1:0] next_value,
  output logic                         gt,
  output logic signed [VALUE_BITS-1:0] value
);

  logic take;

  // The stored value moves up when it is strictly greater than the new one,
  // so equal values keep their arrival order.
  assign gt   = occupied && (value > new_value);
  assign take = gt || (!occupied && prev_occupied);

  always_ff @(posedge clk) begin
    if (ctrl.drain) begin
      value <= next_value;
    end else if (ctrl.insert && take) begin
      value <= prev_gt ? prev_value : new_value;
    end
  end

endmodule

// ===== src/insertion_sorter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Insertion sorter
// Sorts a set of signed values in a chain of compare-and-shift cells and
// emits the set in ascending order.
// ----------------------------------------------------------------------------
// Usage: items arrive on the value/is_last channel (item_valid, item_stall)
// and leave on the sorted_value/is_last_res/overflow channel (result_valid,
// result_stall). Each accepted item is inserted into the cell chain in the
// cycle it is accepted, so a set streams in at one item per cycle while
// item_stall is low. When an item with is_last is accepted, the block
// drains the chain through cell 0, one result per cycle while the receiver
// does not stall. The last item sets the draining flag, after which cell 0
// is loaded into the output register as the first result. During the
// drain, item_stall is high; it drops in the cycle after the final result
// is loaded into the output register. A stalled result simply holds the
// output register and pauses the drain. Items beyond DEPTH are dropped and
// every result of that set carries the overflow flag. Reset empties the
// chain and clears the recorded overflow and the output valid.
// ----------------------------------------------------------------------------
module insertion_sorter import ins_pkg::*; #(
  parameter int DEPTH      = 32,
  parameter int VALUE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic signed [VALUE_BITS-1:0] value,
  input  logic                         is_last,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic signed [VALUE_BITS-1:0] sorted_value,
  output logic                         is_last_res,
  output logic                         overflow
);

  localparam int CNT_BITS = $clog2(DEPTH + 1);

  // Number of occupied cells; cells below this count hold the sorted set.
  logic [CNT_BITS-1:0] element_count;
  logic                overflow_seen;
  logic                draining;

  logic                          accept;
  logic                          full;
  logic                          load;
  cell_ctrl_t                    ctrl;
  logic signed [VALUE_BITS-1:0]  cell_value [DEPTH];
  logic                          cell_gt    [DEPTH];
  logic                          occ        [DEPTH];

  assign item_stall = draining;
  assign accept     = item_valid && !draining;
  assign full       = (element_count == CNT_BITS'(DEPTH));

  // While draining, the output register is refilled whenever it is empty or being taken.
  assign load = draining && (!result_valid || !result_stall);

  assign ctrl.insert = accept && !full;
  assign ctrl.drain  = load;

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic                         prev_occ;
      logic                         prev_gt;
      logic signed [VALUE_BITS-1:0] prev_val;
      logic signed [VALUE_BITS-1:0] next_val;

      assign occ[i] = (element_count > CNT_BITS'(i));

      // Cell 0 has no lower neighbor: whenever it takes a value, it takes the new one.
      if (i == 0) begin : g_first
        assign prev_occ = 1'b1;
        assign prev_gt  = 1'b0;
        assign prev_val = value;
      end else begin : g_inner
        assign prev_occ = occ[i-1];
        assign prev_gt  = cell_gt[i-1];
        assign prev_val = cell_value[i-1];
      end

      // The top cell has no upper neighbor; what it takes during a drain is
      // beyond the count and never read.
      if (i == DEPTH - 1) begin : g_top
        assign next_val = cell_value[i];
      end else begin : g_below
        assign next_val = cell_value[i+1];
      end

      ins_cell #(
        .VALUE_BITS(VALUE_BITS)
      ) u_cell (
        .clk          (clk),
        .ctrl         (ctrl),
        .new_value    (value),
        .occupied     (occ[i]),
        .prev_occupied(prev_occ),
        .prev_gt      (prev_gt),
        .prev_value   (prev_val),
        .next_value   (next_val),
        .gt           (cell_gt[i]),
        .value        (cell_value[i])
      );
    end
  endgenerate

  // Output register payload; valid is handled with the control state.
  always_ff @(posedge clk) begin
    if (load) begin
      sorted_value <= cell_value[0];
      is_last_res  <= (element_count == CNT_BITS'(1));
      overflow     <= overflow_seen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= '0;
      overflow_seen <= 1'b0;
      draining      <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      if (accept) begin
        // A full chain drops the item but still honors its last mark.
        if (full) begin
          overflow_seen <= 1'b1;
        end else begin
          element_count <= element_count + CNT_BITS'(1);
        end
        if (is_last) begin
          draining <= 1'b1;
        end
      end

      if (load) begin
        result_valid  <= 1'b1;
        element_count <= element_count - CNT_BITS'(1);
        if (element_count == CNT_BITS'(1)) begin
          draining      <= 1'b0;
          overflow_seen <= 1'b0;
        end
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule
